// ===== src/ntc_pkg.sv =====
package ntc_pkg;

    // Field and datapath widths.
    localparam int CODE_W   = 12;
    localparam int OUT_W    = 14;
    localparam int Q_W      = 24;
    localparam int NUM_W    = 32;
    localparam int REM_W    = Q_W;
    localparam int FRAC_W   = 7;
    localparam int CNT_W    = 6;
    localparam int FS_W     = 16;
    localparam int CALC_W   = 16;
    localparam int STORE_AW = 8;

    // Divider step counts: full quotient for the resistance, seven bits for the fraction.
    localparam int DIV_LONG_STEPS  = NUM_W;
    localparam int DIV_SHORT_STEPS = FRAC_W;

    // Conversion constants.
    localparam int R_FIXED_KOHM = 10;
    localparam int T_MIN_DEG    = -40;
    localparam int CENTI        = 100;
    localparam int OUT_MAX      = 16383;
    // First table index whose lower neighbor lies at or above 0 degrees.
    localparam int ZERO_DEG_IDX = 1 - T_MIN_DEG;

    // Stored resistance table in units of 0.0001 kilo-ohm, one entry per degree from -40.
    localparam int STORED_LEN = 166;
    localparam longint unsigned RES_SCALE = 10000;
    localparam longint unsigned RES_ROUND = 5000;
    localparam longint unsigned Q_ONE     = 65536;

    localparam int unsigned RES_E4 [STORED_LEN] = '{
        1956520, 1849171, 1748452, 1653910, 1565125, 1481710, 1403304,
        1329576, 1260215, 1194936, 1133471, 1075649, 1021155, 969776,
        921315, 875588, 832424, 791663, 753157, 716768, 682367,
        649907, 619190, 590113, 562579, 536496, 511779, 488349,
        466132, 445058, 425062, 405997, 387905, 370729, 354417,
        338922, 324197, 310200, 296890, 284231, 272186, 260760,
        249877, 239509, 229629, 220211, 211230, 202666, 194495,
        186698, 179255, 172139, 165344, 158856, 152658, 146735,
        141075, 135664, 130489, 125540, 120805, 116281, 111947,
        107795, 103815, 100000, 96342, 92835, 89470, 86242,
        83145, 80181, 77337, 74609, 71991, 69479, 67067,
        64751, 62526, 60390, 58336, 56357, 54454, 52623,
        50863, 49169, 47539, 45971, 44461, 43008, 41609,
        40262, 38964, 37714, 36510, 35350, 34231, 33152,
        32113, 31110, 30143, 29224, 28337, 27482, 26657,
        25861, 25093, 24351, 23635, 22943, 22275, 21627,
        21001, 20396, 19811, 19245, 18698, 18170, 17658,
        17164, 16685, 16224, 15777, 15345, 14927, 14521,
        14129, 13749, 13381, 13025, 12680, 12343, 12016,
        11700, 11393, 11096, 10807, 10528, 10256, 9993,
        9738, 9492, 9254, 9022, 8798, 8580, 8368,
        8162, 7963, 7769, 7580, 7397, 7219, 7046,
        6878, 6715, 6556, 6402, 6252, 6106, 5964,
        5826, 5692, 5562, 5435, 5311
    };

    typedef logic [Q_W-1:0] t_q16;
    typedef t_q16 t_q16_tab [STORED_LEN];

    // Converts the stored table to Q8.16, rounded to nearest; evaluated at elaboration.
    function automatic t_q16_tab build_q16_table();
        t_q16_tab tab;
        for (int k = 0; k < STORED_LEN; k++) begin
            tab[k] = Q_W'((longint'(RES_E4[k]) * Q_ONE + RES_ROUND) / RES_SCALE);
        end
        return tab;
    endfunction

    // Divider control.
    typedef struct packed {
        logic start;
        logic narrow;
    } t_div_req;

    typedef struct packed {
        logic done;
    } t_div_rsp;

    // Conversion sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_DIV,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RD_HI,
        S_RD_LO,
        S_FRAC_SETUP,
        S_FRAC_DIV,
        S_DONE
    } t_state;

endpackage

// ===== src/ntc_if.sv =====
// Channel carrying one converter reading per item.
interface ntc_adc_if;
    import ntc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

// Channel carrying one temperature per item.
interface ntc_temp_if;
    import ntc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] temp_centideg;

    modport source (output valid, output temp_centideg, input ready);
    modport sink   (input valid, input temp_centideg, output ready);
endinterface

// ===== src/ntc_rom.sv =====
module ntc_rom #(
    parameter int AW = 8
) (
    input  logic                 i_clk,
    input  logic [AW-1:0]        i_addr,
    output ntc_pkg::t_q16        o_data
);
    import ntc_pkg::*;

    // Resistance table in Q8.16, held as a synchronous read-only memory.
    localparam t_q16_tab ROM = build_q16_table();

    logic [STORE_AW-1:0] w_idx;
    t_q16                r_data;

    // Addresses past the stored data read the last stored entry.
    always_comb begin
        w_idx = STORE_AW'(i_addr);
        if (w_idx >= STORE_AW'(STORED_LEN)) begin
            w_idx = STORE_AW'(STORED_LEN - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= ROM[w_idx];
    end

    assign o_data = r_data;

endmodule

// ===== src/ntc_div.sv =====
module ntc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ntc_pkg::t_div_req         i_req,
    input  logic [ntc_pkg::NUM_W-1:0] i_num,
    input  logic [ntc_pkg::REM_W-1:0] i_den,
    output ntc_pkg::t_div_rsp         o_rsp,
    output logic [ntc_pkg::NUM_W-1:0] o_quot
);
    import ntc_pkg::*;

    // Restoring divider, one quotient bit per cycle. In narrow mode the caller
    // guarantees a quotient below 2**FRAC_W, so only the low bits are worked.
    logic [REM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quot;
    logic [REM_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [REM_W:0]   w_trial;
    logic             w_ge;

    // Trial subtraction of one step.
    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    // Control: step count and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_cnt <= i_req.narrow ? CNT_W'(DIV_SHORT_STEPS) : CNT_W'(DIV_LONG_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath: load operands, then shift and subtract.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den  <= i_den;
            r_quot <= '0;
            if (i_req.narrow) begin
                r_rem <= i_num[DIV_SHORT_STEPS +: REM_W];
                r_num <= i_num << (NUM_W - DIV_SHORT_STEPS);
            end else begin
                r_rem <= '0;
                r_num <= i_num;
            end
        end else if (r_cnt != '0) begin
            r_num  <= r_num << 1;
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
            if (w_ge) begin
                r_rem <= REM_W'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= REM_W'(w_trial);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_quot     = r_quot;

endmodule

// ===== src/ntc_adc_to_temperature_core.sv =====
// Converts one 12-bit reading of an NTC divider with a 10 kilo-ohm fixed resistor
// into a temperature in hundredths of a degree C (0 to 12500 with the default table;
// readings below 0 C and a reading at full scale give 0). The resistance is found
// with a bit-serial divider, located in a synchronous resistance ROM by a binary
// search, and interpolated with a second, 7-bit pass of the same divider. One item
// is converted at a time, through the shared divider (32 + 7 steps) and a
// synchronous ROM read for each search step. Readings that saturate or land
// below 0 C finish earlier. A finished result waits in the output register
// while the next item is already accepted.
module ntc_adc_to_temperature_core #(
    parameter int TABLE_LEN      = 166,
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntc_adc_if.sink     i_adc,
    ntc_temp_if.source  o_temp
);
    import ntc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_LEN + 1);
    localparam int AW    = $clog2(TABLE_LEN);

    // Result when the resistance lies at or below the last table entry.
    localparam int TOP_C   = (T_MIN_DEG + TABLE_LEN - 1) * CENTI;
    localparam int TOP_SAT = (TOP_C < 0) ? 0 : ((TOP_C > OUT_MAX) ? OUT_MAX : TOP_C);

    t_state              r_state;
    t_state              n_state;

    logic [CODE_W-1:0]   r_code;
    logic [NUM_W-1:0]    r_r;
    logic [IDX_W-1:0]    r_lo;
    logic [IDX_W-1:0]    r_hi;
    logic [IDX_W-1:0]    r_mid;
    t_q16                r_qhi;
    logic [OUT_W-1:0]    r_result;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic                w_accept;
    logic                w_out_free;
    logic                w_code_full;
    logic                w_srch_more;
    logic                w_no_interp;
    logic [IDX_W-1:0]    w_mid;
    logic [AW-1:0]       w_rom_addr;
    t_q16                w_rom_data;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;
    logic [NUM_W-1:0]    w_div_num;
    logic [REM_W-1:0]    w_div_den;
    logic [NUM_W-1:0]    w_div_quot;
    logic [FS_W-1:0]     w_den;
    logic [CALC_W-1:0]   w_code10;
    logic [Q_W-1:0]      w_diff;
    logic [NUM_W-1:0]    w_frac_num;
    logic [CALC_W-1:0]   w_temp;

    // Resistance table and shared divider.
    ntc_rom #(
        .AW (AW)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    ntc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_rsp   (w_div_rsp),
        .o_quot  (w_div_quot)
    );

    // Conditions derived from the current item.
    always_comb begin
        w_accept    = i_adc.valid && (r_state == S_IDLE);
        w_out_free  = !r_out_valid || o_temp.ready;
        w_code_full = (FS_W'(r_code) >= FS_W'(ADC_FULL_SCALE));
        w_den       = FS_W'(ADC_FULL_SCALE) - FS_W'(r_code);
        w_code10    = CALC_W'({r_code, 3'b000}) + CALC_W'({r_code, 1'b0});
        w_srch_more = (r_lo < r_hi);
        w_no_interp = (r_lo == IDX_W'(TABLE_LEN)) ||
                      (CALC_W'(r_lo) < CALC_W'(ZERO_DEG_IDX));
        w_mid       = IDX_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
        // The search leaves the lower entry below r and the upper one at or above it,
        // so the span is never zero and the fraction stays below 100.
        w_diff      = r_qhi - r_r[Q_W-1:0];
        w_frac_num  = (NUM_W'(w_diff) << 6) + (NUM_W'(w_diff) << 5) + (NUM_W'(w_diff) << 2);
        w_temp      = CALC_W'(CALC_W'(r_lo) - CALC_W'(ZERO_DEG_IDX)) * CALC_W'(CENTI)
                      + CALC_W'(w_div_quot[FRAC_W-1:0]);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = w_code_full ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (w_srch_more) begin
                    n_state = S_SRCH_CMP;
                end else if (w_no_interp) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD_HI;
                end
            end
            S_SRCH_CMP:   n_state = S_SRCH_RD;
            S_RD_HI:      n_state = S_RD_LO;
            S_RD_LO:      n_state = S_FRAC_SETUP;
            S_FRAC_SETUP: n_state = S_FRAC_DIV;
            S_FRAC_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: ROM address, divider request and operands.
    always_comb begin
        w_rom_addr       = '0;
        w_div_req.start  = 1'b0;
        w_div_req.narrow = 1'b0;
        w_div_num        = {w_code10, 16'h0000};
        w_div_den        = REM_W'(w_den);
        i_adc.ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_adc.ready = 1'b1;
            end
            S_CHK: begin
                w_div_req.start = !w_code_full;
            end
            S_SRCH_RD: begin
                w_rom_addr = AW'(w_mid);
            end
            S_RD_HI: begin
                w_rom_addr = AW'(r_lo - 1'b1);
            end
            S_RD_LO: begin
                w_rom_addr = AW'(r_lo);
            end
            S_FRAC_SETUP: begin
                w_div_req.start  = 1'b1;
                w_div_req.narrow = 1'b1;
                w_div_num        = w_frac_num;
                w_div_den        = r_qhi - w_rom_data;
            end
            default: begin
                w_rom_addr = '0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the item being converted.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_code <= i_adc.adc_code;
                end
            end
            S_CHK: begin
                r_result <= '0;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_r  <= w_div_quot;
                    r_lo <= '0;
                    r_hi <= IDX_W'(TABLE_LEN);
                end
            end
            S_SRCH_RD: begin
                r_mid <= w_mid;
                if (r_lo == IDX_W'(TABLE_LEN)) begin
                    r_result <= OUT_W'(TOP_SAT);
                end else begin
                    r_result <= '0;
                end
            end
            S_SRCH_CMP: begin
                // First index whose entry lies below r.
                if (r_r > NUM_W'(w_rom_data)) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= IDX_W'(r_mid + 1'b1);
                end
            end
            S_RD_LO: begin
                r_qhi <= w_rom_data;
            end
            S_FRAC_DIV: begin
                if (w_div_rsp.done) begin
                    if (w_temp > CALC_W'(OUT_MAX)) begin
                        r_result <= OUT_W'(OUT_MAX);
                    end else begin
                        r_result <= OUT_W'(w_temp);
                    end
                end
            end
            default: begin
                r_result <= r_result;
            end
        endcase
    end

    // Output register: a finished item waits here until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_temp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_data <= r_result;
        end
    end

    assign o_temp.valid         = r_out_valid;
    assign o_temp.temp_centideg = r_out_data;

endmodule

// ===== bench/tb_ntc_adc_to_temperature_core.sv =====
`timescale 1ns / 1ps

module tb_ntc_adc_to_temperature_core;
    import ntc_pkg::*;

    localparam int TAB_LEN        = 166;
    localparam int FULL_SCALE     = 4095;
    localparam int STORED_ENTRIES = 166;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // Thermistor resistance per degree from -40 C, in units of 0.0001 kilo-ohm.
    localparam int unsigned KOHM_E4 [STORED_ENTRIES] = '{
        1956520, 1849171, 1748452, 1653910, 1565125, 1481710, 1403304,
        1329576, 1260215, 1194936, 1133471, 1075649, 1021155, 969776,
        921315, 875588, 832424, 791663, 753157, 716768, 682367,
        649907, 619190, 590113, 562579, 536496, 511779, 488349,
        466132, 445058, 425062, 405997, 387905, 370729, 354417,
        338922, 324197, 310200, 296890, 284231, 272186, 260760,
        249877, 239509, 229629, 220211, 211230, 202666, 194495,
        186698, 179255, 172139, 165344, 158856, 152658, 146735,
        141075, 135664, 130489, 125540, 120805, 116281, 111947,
        107795, 103815, 100000, 96342, 92835, 89470, 86242,
        83145, 80181, 77337, 74609, 71991, 69479, 67067,
        64751, 62526, 60390, 58336, 56357, 54454, 52623,
        50863, 49169, 47539, 45971, 44461, 43008, 41609,
        40262, 38964, 37714, 36510, 35350, 34231, 33152,
        32113, 31110, 30143, 29224, 28337, 27482, 26657,
        25861, 25093, 24351, 23635, 22943, 22275, 21627,
        21001, 20396, 19811, 19245, 18698, 18170, 17658,
        17164, 16685, 16224, 15777, 15345, 14927, 14521,
        14129, 13749, 13381, 13025, 12680, 12343, 12016,
        11700, 11393, 11096, 10807, 10528, 10256, 9993,
        9738, 9492, 9254, 9022, 8798, 8580, 8368,
        8162, 7963, 7769, 7580, 7397, 7219, 7046,
        6878, 6715, 6556, 6402, 6252, 6106, 5964,
        5826, 5692, 5562, 5435, 5311
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [OUT_W-1:0]  temp;
    } t_pending_reading;

    logic i_clk;
    logic i_rst_n;

    ntc_adc_if  adc_ch ();
    ntc_temp_if temp_ch ();

    ntc_adc_to_temperature_core #(
        .TABLE_LEN      (TAB_LEN),
        .ADC_FULL_SCALE (FULL_SCALE)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adc   (adc_ch),
        .o_temp  (temp_ch)
    );

    t_pending_reading pending_temps [$];
    t_pending_reading head;

    int tx_idle_pct;
    int rx_idle_pct;
    int stall_requests;
    int stall_served;
    int hold_left;
    int readings_sent;
    int directed_sent;
    int temps_checked;
    int mismatches;
    int quiet_cycles;

    // Table entry as Q8.16 kilo-ohms, rounded to nearest; indexes past the end repeat the last.
    function automatic longint unsigned entry_q16(int idx);
        int k;
        k = (idx >= STORED_ENTRIES) ? STORED_ENTRIES - 1 : idx;
        return (longint'(KOHM_E4[k]) * 65536 + 5000) / 10000;
    endfunction

    // Thermistor resistance in Q8.16 kilo-ohms for a reading below full scale, truncated.
    function automatic longint unsigned resistance_q16(logic [CODE_W-1:0] code);
        return (longint'(code) * 10 * 65536) / longint'(FULL_SCALE - code);
    endfunction

    // Temperature in hundredths of a degree that the block must return for one reading.
    function automatic logic [OUT_W-1:0] predict_centideg(logic [CODE_W-1:0] code);
        longint unsigned r;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned frac;
        longint          t;
        int              i;
        if (code >= FULL_SCALE)
            return '0;
        r = resistance_q16(code);
        if (r <= entry_q16(TAB_LEN - 1)) begin
            t = longint'(-40 + TAB_LEN - 1) * 100;
            return (t > 16383) ? OUT_W'(16383) : OUT_W'(t);
        end
        if (r > entry_q16(0))
            return '0;
        for (i = 1; i < TAB_LEN - 1; i++) begin
            if (r > entry_q16(i))
                break;
        end
        t = -40 + i - 1;
        // Everything below the freezing point clamps to zero.
        if (t < 0)
            return '0;
        hi   = entry_q16(i - 1);
        lo   = entry_q16(i);
        frac = 0;
        if (hi > lo && hi >= r) begin
            frac = ((hi - r) * 100) / (hi - lo);
            if (frac > 99)
                frac = 99;
        end
        t = t * 100 + longint'(frac);
        return (t > 16383) ? OUT_W'(16383) : OUT_W'(t);
    endfunction

    // Largest reading whose resistance is still at or below the given table entry.
    function automatic logic [CODE_W-1:0] code_at_entry(int idx);
        logic [CODE_W-1:0] best;
        best = '0;
        for (int c = 0; c < FULL_SCALE; c++) begin
            if (resistance_q16(CODE_W'(c)) <= entry_q16(idx))
                best = CODE_W'(c);
        end
        return best;
    endfunction

    // Mostly readings inside the table span, some anywhere, some near the saturated ends.
    function automatic logic [CODE_W-1:0] random_reading();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65)
            return CODE_W'($urandom_range(3050, 150));
        else if (sel < 85)
            return CODE_W'($urandom_range(FULL_SCALE, 0));
        else if (sel < 92)
            return CODE_W'($urandom_range(220, 0));
        else
            return CODE_W'($urandom_range(FULL_SCALE, 2980));
    endfunction

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one reading, with random gaps first, and records its expected temperature.
    task automatic send_reading(input logic [CODE_W-1:0] code);
        while ($urandom_range(99) < tx_idle_pct) begin
            adc_ch.valid    <= 1'b0;
            adc_ch.adc_code <= CODE_W'($urandom);
            @(posedge i_clk);
        end
        adc_ch.valid    <= 1'b1;
        adc_ch.adc_code <= code;
        @(posedge i_clk);
        while (!adc_ch.ready)
            @(posedge i_clk);
        pending_temps.push_back('{code: code, temp: predict_centideg(code)});
        readings_sent++;
    endtask

    // Output side: random back-pressure, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (stall_requests != stall_served) begin
            stall_served  <= stall_requests;
            hold_left     <= HOLD_CYCLES;
            temp_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            temp_ch.ready <= 1'b0;
        end else begin
            temp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each delivered temperature with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && temp_ch.valid && temp_ch.ready) begin
            temps_checked++;
            if (pending_temps.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected temperature %0d with no reading outstanding",
                             temp_ch.temp_centideg);
            end else begin
                head = pending_temps.pop_front();
                if (temp_ch.temp_centideg !== head.temp) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("code %0d: temp_centideg expected %0d, got %0d",
                                 head.code, head.temp, temp_ch.temp_centideg);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (adc_ch.valid && adc_ch.ready) || (temp_ch.valid && temp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Full-scale, zero, bit patterns and the crossings at both table ends, at 0 C and at 60 C.
    task automatic test_table_edges();
        int                edge_idx [6];
        logic [CODE_W-1:0] fixed_codes [7];
        logic [CODE_W-1:0] c;
        edge_idx    = '{0, 39, 40, 41, 100, TAB_LEN - 1};
        fixed_codes = '{12'd0, 12'd1, 12'd2048, 12'h555, 12'hAAA, 12'd4094, 12'd4095};
        tx_idle_pct = 33;
        rx_idle_pct <= 58;
        foreach (fixed_codes[k]) begin
            send_reading(fixed_codes[k]);
            directed_sent++;
        end
        foreach (edge_idx[k]) begin
            c = code_at_entry(edge_idx[k]);
            send_reading(c);
            send_reading(c + 1'b1);
            directed_sent += 2;
        end
    endtask

    task automatic test_random_readings(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        repeat (count)
            send_reading(random_reading());
    endtask

    // Output held off for a long stretch while readings keep coming, so the input stalls.
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        stall_requests <= stall_requests + 1;
        repeat (30)
            send_reading(random_reading());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        adc_ch.valid    = 1'b0;
        adc_ch.adc_code = '0;
        temp_ch.ready   = 1'b0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        stall_requests  = 0;
        stall_served    = 0;
        hold_left       = 0;
        readings_sent   = 0;
        directed_sent   = 0;
        temps_checked   = 0;
        mismatches      = 0;
        quiet_cycles    = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_edges();
        test_random_readings(250, 33, 58);
        test_random_readings(250, 58, 33);
        test_output_stall();
        test_random_readings(170, 0, 0);

        // Drain: every prediction must be consumed, then nothing more may arrive.
        adc_ch.valid <= 1'b0;
        rx_idle_pct  <= 0;
        while (pending_temps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d readings (%0d directed at table ends, 0 C and full scale), checked %0d.",
                 readings_sent, directed_sent, temps_checked);
        $display("Idling on either side, none at all, and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending_temps.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d readings without a result", mismatches,
                     pending_temps.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ntc_pkg.sv
src/ntc_if.sv
src/ntc_rom.sv
src/ntc_div.sv
src/ntc_adc_to_temperature_core.sv
bench/tb_ntc_adc_to_temperature_core.sv
